FILE: design/tskf_pkg.sv
// ----------------------------------------------------------------------------
// tskf_pkg
// Shared types and constants for the three-axis scalar Kalman filter.
// ----------------------------------------------------------------------------
package tskf_pkg;

    localparam int unsigned SAMPLE_WIDTH = 16;
    localparam int unsigned VAR_W   = 15;
    localparam int unsigned NOISE_W = 15;
    localparam int unsigned BIAS_W  = 48;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned AXES    = 3;
    localparam int unsigned SENSORS = 3;

    localparam logic [VAR_W-1:0] VAR_MAX = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_NOISE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_NOISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNET_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNET_BIAS  = 3'd5;

    localparam logic [1:0] FUNC_ACCEL  = 2'd0;
    localparam logic [1:0] FUNC_GYRO   = 2'd1;
    localparam logic [1:0] FUNC_MAGNET = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_START,
        t_ST_RUN,
        t_ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        t_LS_IDLE,
        t_LS_MUL,
        t_LS_DIV,
        t_LS_FIX,
        t_LS_DONE
    } t_lane_state;

endpackage

FILE: design/tskf_div.sv
// ----------------------------------------------------------------------------
// tskf_div
// Restoring serial divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tskf_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        n_quo   = {r_quo[NUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: design/tskf_lane.sv
// ----------------------------------------------------------------------------
// tskf_lane
// One axis of the scalar Kalman update: multiply, two serial divisions, fix.
// ----------------------------------------------------------------------------
module tskf_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic signed [tskf_pkg::SAMPLE_WIDTH-1:0] i_z,
    input  logic signed [tskf_pkg::SAMPLE_WIDTH-1:0] i_s,
    input  logic [tskf_pkg::VAR_W-1:0]               i_p,
    input  logic [tskf_pkg::NOISE_W-1:0]             i_noise,
    output logic                                     o_done,
    output logic signed [tskf_pkg::SAMPLE_WIDTH-1:0] o_s,
    output logic [tskf_pkg::VAR_W-1:0]               o_p
);
    import tskf_pkg::*;

    localparam int unsigned D_W   = SAMPLE_WIDTH + 2;
    localparam int unsigned Q_W   = VAR_W + 1;
    localparam int unsigned NUM_W = SAMPLE_WIDTH + Q_W + 2;

    t_lane_state r_st, n_st;

    logic signed [D_W-1:0]   w_d;
    logic [D_W-1:0]          w_abs;
    logic [VAR_W-1:0]        w_r;
    logic [Q_W-1:0]          w_q;

    logic signed [SAMPLE_WIDTH-1:0] r_s;
    logic signed [D_W-1:0]          r_d;
    logic [VAR_W-1:0]        r_p, r_r;
    logic [Q_W-1:0]          r_q;
    logic [NOISE_W-1:0]      r_noise;
    logic                    r_neg;

    logic signed [NUM_W-1:0] w_num;
    logic [NUM_W-1:0]        w_mag;
    logic [2*VAR_W-1:0]      w_pr;
    logic                    w_div_go;
    logic                    w_done_a, w_done_b;
    logic [NUM_W-1:0]        w_quo_a, w_quo_b;
    logic [NUM_W-1:0]        w_quo_s;
    logic [Q_W:0]            w_np;
    logic signed [SAMPLE_WIDTH-1:0] r_os;
    logic [VAR_W-1:0]        r_op;

    assign w_d   = D_W'(i_z) - D_W'(i_s);
    assign w_abs = w_d[D_W-1] ? D_W'(-w_d) : D_W'(w_d);
    assign w_r   = (w_abs > D_W'(VAR_MAX)) ? VAR_MAX : w_abs[VAR_W-1:0];
    assign w_q   = Q_W'(i_p) + Q_W'(w_r);

    assign w_num = NUM_W'(r_s) * $signed({1'b0, r_q})
                 + NUM_W'($signed({1'b0, r_p})) * NUM_W'(r_d);
    assign w_mag = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
    assign w_pr  = r_p * r_r;

    assign w_div_go = (r_st == t_LS_MUL) && (r_q != '0);

    tskf_div #(.NUM_W(NUM_W), .DEN_W(Q_W)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_go),
        .i_num(w_mag), .i_den(r_q), .o_done(w_done_a), .o_quo(w_quo_a)
    );

    tskf_div #(.NUM_W(NUM_W), .DEN_W(Q_W)) u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_go),
        .i_num(NUM_W'(w_pr)), .i_den(r_q), .o_done(w_done_b), .o_quo(w_quo_b)
    );

    assign w_quo_s = r_neg ? NUM_W'(-w_quo_a) : w_quo_a;
    assign w_np    = (Q_W+1)'(w_quo_b[VAR_W-1:0]) + (Q_W+1)'(r_noise);

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_LS_IDLE: if (i_start) n_st = t_LS_MUL;
            t_LS_MUL:  n_st = (r_q == '0) ? t_LS_DONE : t_LS_DIV;
            t_LS_DIV:  if (w_done_a) n_st = t_LS_FIX;
            t_LS_FIX:  n_st = t_LS_DONE;
            t_LS_DONE: n_st = t_LS_IDLE;
            default:   n_st = t_LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_LS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == t_LS_IDLE && i_start) begin
            r_s     <= i_s;
            r_d     <= w_d;
            r_p     <= i_p;
            r_r     <= w_r;
            r_q     <= w_q;
            r_noise <= i_noise;
        end
        if (r_st == t_LS_MUL) begin
            r_neg <= w_num[NUM_W-1];
            r_os  <= r_s;
            r_op  <= r_noise;
        end
        if (r_st == t_LS_FIX) begin
            r_os <= w_quo_s[SAMPLE_WIDTH-1:0];
            r_op <= (w_np > (Q_W+1)'(VAR_MAX)) ? VAR_MAX : w_np[VAR_W-1:0];
        end
    end

    assign o_done = (r_st == t_LS_DONE);
    assign o_s    = r_os;
    assign o_p    = r_op;

    logic w_unused;
    assign w_unused = ^{w_done_b, w_quo_b[NUM_W-1:VAR_W]};
endmodule

FILE: design/three_axis_scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// three_axis_scalar_kalman_filter_core
// Bias removal and three parallel scalar Kalman lanes over nine axis states.
//
//  Channel  Dir  Signals                    Content
//  s_axis   in   tvalid/tready/tdata/tuser  x[15:0], y[31:16], z[47:32]; func
//  m_axis   out  tvalid/tready/tdata        x[15:0], y[31:16], z[47:32]
//  cfg      in   we/idx/data                noise and bias registers
//
//  An item passes through the start, run and output states, set by the
//  34-step serial dividers in each lane; the three axes run at once. The
//  unused selector skips the lanes and goes from accept straight to output.
//  A new item is taken only in the idle state, once the result register is
//  empty or being taken. Reset clears all variances and estimates.
// ----------------------------------------------------------------------------
module three_axis_scalar_kalman_filter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_sample, y_sample, z_sample
    input  logic [47:0]                     s_axis_tdata,
    // func
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // x_filtered, y_filtered, z_filtered
    output logic [47:0]                     m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [tskf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tskf_pkg::BIAS_W-1:0]     i_cfg_data
);
    import tskf_pkg::*;

    localparam int unsigned SW = SAMPLE_WIDTH;

    t_state r_st, n_st;
    logic [NOISE_W-1:0] r_noise [SENSORS];
    logic [BIAS_W-1:0]  r_bias  [SENSORS];
    logic [VAR_W-1:0]   r_var   [SENSORS*AXES];
    logic signed [SW-1:0] r_est [SENSORS*AXES];
    logic [1:0]         r_func;
    logic signed [SW-1:0] r_z [AXES];
    logic [47:0]        r_out;
    logic               r_ovalid;
    logic [AXES-1:0]    w_done;
    logic signed [SW-1:0] w_s [AXES];
    logic [VAR_W-1:0]   w_p [AXES];
    logic [1:0]         w_fn;
    logic [3:0]         w_base;
    logic               w_acc;
    logic               w_start;

    assign w_fn  = s_axis_tuser;
    assign w_base = 4'(r_func) * 4'(AXES);
    assign s_axis_tready = (r_st == t_ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_start = (r_st == t_ST_START);

    always_comb begin
        n_st = r_st;
        case (r_st)
            t_ST_IDLE:  if (w_acc) n_st = (w_fn == FUNC_UNUSED) ? t_ST_OUT : t_ST_START;
            t_ST_START: n_st = t_ST_RUN;
            t_ST_RUN:   if (w_done[0]) n_st = t_ST_OUT;
            t_ST_OUT:   n_st = t_ST_IDLE;
            default:    n_st = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_ST_IDLE;
            r_ovalid <= 1'b0;
            r_noise[0] <= 15'd1;
            r_noise[1] <= 15'd1;
            r_noise[2] <= 15'd10;
            for (int i = 0; i < SENSORS; i++) r_bias[i] <= '0;
            for (int i = 0; i < SENSORS*AXES; i++) begin
                r_var[i] <= '0;
                r_est[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (r_st == t_ST_OUT) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACCEL_NOISE:  r_noise[0] <= i_cfg_data[NOISE_W-1:0];
                    REG_GYRO_NOISE:   r_noise[1] <= i_cfg_data[NOISE_W-1:0];
                    REG_MAGNET_NOISE: r_noise[2] <= i_cfg_data[NOISE_W-1:0];
                    REG_ACCEL_BIAS:   r_bias[0]  <= i_cfg_data;
                    REG_GYRO_BIAS:    r_bias[1]  <= i_cfg_data;
                    REG_MAGNET_BIAS:  r_bias[2]  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == t_ST_RUN && w_done[0]) begin
                for (int a = 0; a < AXES; a++) begin
                    r_var[w_base + 4'(a)] <= w_p[a];
                    r_est[w_base + 4'(a)] <= w_s[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func <= w_fn;
            for (int a = 0; a < AXES; a++) begin
                r_z[a] <= SW'($signed(s_axis_tdata[16*a +: 16]))
                        - ((w_fn == FUNC_UNUSED) ? SW'(0)
                           : SW'($signed(r_bias[w_fn][16*a +: 16])));
            end
        end
        if (r_st == t_ST_OUT) begin
            for (int a = 0; a < AXES; a++) begin
                r_out[16*a +: 16] <= (r_func == FUNC_UNUSED) ? 16'd0
                                    : r_est[w_base + 4'(a)][15:0];
            end
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        tskf_lane u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
            .i_z(r_z[a]), .i_s(r_est[w_base + 4'(a)]), .i_p(r_var[w_base + 4'(a)]),
            .i_noise(r_noise[r_func]), .o_done(w_done[a]),
            .o_s(w_s[a]), .o_p(w_p[a])
        );
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    logic w_unused;
    assign w_unused = ^{w_done[2:1]};
endmodule

FILE: tb/three_axis_scalar_kalman_filter_core_test.sv
// ----------------------------------------------------------------------------
// three_axis_scalar_kalman_filter_core_test
// Drives sensor samples through the Kalman filter core under random idling,
// predicts each filtered x, y, z triple from a local copy of the variance,
// estimate, noise and bias state, and compares every result in order.
// ----------------------------------------------------------------------------
module three_axis_scalar_kalman_filter_core_test;
    import tskf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BIAS_W-1:0]    i_cfg_data;

    three_axis_scalar_kalman_filter_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic [14:0] noise_q [3];
    logic [47:0] bias_q [3];
    logic [14:0] var_q [9];
    logic signed [15:0] est_q [9];
    logic [47:0] filtered_q [$];
    int mismatches;
    int cycles;
    int hold_cycles;
    int rx_gap;
    bit timed_out;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000 && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] filter_axis(int k, logic signed [15:0] z,
                                                        logic [14:0] noise);
        longint p, s, d, r, q, np;
        logic signed [15:0] sn;
        p = var_q[k];
        s = est_q[k];
        d = longint'(z) - s;
        r = d < 0 ? -d : d;
        if (r > 32767) r = 32767;
        q = p + r;
        sn = est_q[k];
        if (q == 0) begin
            np = noise;
        end else begin
            np = (p * r) / q + noise;
            sn = 16'((s * q + p * d) / q);
        end
        if (np > 32767) np = 32767;
        var_q[k] = 15'(np);
        est_q[k] = sn;
        return sn;
    endfunction

    function automatic logic [47:0] predict_filtered(logic [55:0] d);
        logic [47:0] res;
        logic signed [15:0] raw, b, z;
        int sensor;
        sensor = d[1:0];
        res = '0;
        if (d[1:0] != FUNC_UNUSED) begin
            for (int a = 0; a < 3; a++) begin
                raw = d[2 + 16 * a +: 16];
                b = bias_q[sensor][16 * a +: 16];
                z = raw - b;
                res[16 * a +: 16] = filter_axis(sensor * 3 + a, z, noise_q[sensor]);
            end
        end
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BIAS_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_MAGNET_NOISE) noise_q[idx] = val[14:0];
        else if (idx <= REG_MAGNET_BIAS) bias_q[idx - REG_ACCEL_BIAS] = val;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [1:0] func, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        filtered_q.push_back(predict_filtered({6'b0, z, y, x, func}));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // receiver: random idling per item, optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_gap = $urandom_range(0, 3);
            m_axis_tready <= (rx_gap == 0);
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            m_axis_tready <= (rx_gap == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [47:0] exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_axis_tdata);
            end else begin
                exp_v = filtered_q.pop_front();
                for (int a = 0; a < 3; a++)
                    if (exp_v[16 * a +: 16] !== m_axis_tdata[16 * a +: 16]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("axis %0d: expected %h, got %h", a,
                                     exp_v[16 * a +: 16], m_axis_tdata[16 * a +: 16]);
                    end
            end
        end
    end

    task automatic test_extremes();
        logic [15:0] ext [4];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        send_sample(FUNC_ACCEL, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 4; i++)
            send_sample(FUNC_ACCEL, ext[i], ext[3 - i], ext[i]);
        send_sample(FUNC_GYRO, 16'h7FFF, 16'h8000, 16'h1234);
        send_sample(FUNC_MAGNET, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(FUNC_UNUSED, 16'h5555, 16'hAAAA, 16'h7FFF);
        send_sample(FUNC_MAGNET, 16'h0100, 16'h0100, 16'h0100);
        wait_idle();
    endtask

    task automatic test_config();
        write_reg(REG_ACCEL_NOISE, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_GYRO_NOISE, 48'd0);
        write_reg(REG_MAGNET_NOISE, 48'h7FFF);
        write_reg(REG_ACCEL_BIAS, 48'h8000_7FFF_FFFF);
        write_reg(REG_GYRO_BIAS, 48'h0001_8000_7FFF);
        write_reg(REG_MAGNET_BIAS, 48'h1234_FFFF_8000);
        write_reg(3'd6, 48'h5A5A);
        write_reg(3'd7, 48'hA5A5);
        for (int i = 0; i < 12; i++)
            send_sample(2'(i % 4), 16'(i * 4099), 16'h8000 ^ 16'(i), 16'h7FFF - 16'(i));
        wait_idle();
        write_reg(REG_ACCEL_NOISE, 48'd0);
        write_reg(REG_GYRO_NOISE, 48'd1);
        write_reg(REG_MAGNET_NOISE, 48'd0);
        // zero-divisor path: estimate equals sample, variance zero
        send_sample(FUNC_MAGNET, 16'h0200, 16'h0000, 16'h0100);
        send_sample(FUNC_MAGNET, 16'h0200, 16'h0000, 16'h0100);
        wait_idle();
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), 48'({$urandom, $urandom}) &
                                 ((r < 3 && ph % 2) ? 48'h7 : 48'hFFFF_FFFF_FFFF));
            for (int i = 0; i < per_phase; i++) begin
                logic [1:0] f;
                f = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2));
                if ($urandom_range(0, 1))
                    send_sample(f, 16'($urandom), 16'($urandom), 16'($urandom));
                else
                    send_sample(f, 16'($urandom_range(0, 200)) - 16'd100,
                                16'($urandom_range(0, 200)) - 16'd100,
                                16'($urandom_range(0, 200)) - 16'd100);
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send_sample(2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom),
                        16'($urandom), 1);
        wait_idle();
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        hold_cycles = 0;
        rx_gap = 0;
        timed_out = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        noise_q = '{15'd1, 15'd1, 15'd10};
        bias_q = '{48'd0, 48'd0, 48'd0};
        for (int k = 0; k < 9; k++) begin
            var_q[k] = '0;
            est_q[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_config();
        test_backpressure();
        test_random(4, 90);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
